[rtl/core/lfk_pkg.sv]
`timescale 1ns / 1ps

package lfk_pkg;

  // Fixed widths
  localparam int Q14_W     = 16;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 4;
  localparam int PINT_W    = 22;   // internal position, micrometres
  localparam int ZW        = 20;   // CORDIC angle residue, Q.16
  localparam int XYW       = 33;   // CORDIC vector, Q.30
  localparam int RED_BASE  = 20;   // reduction word width before extra steps

  // Angle constants in Q.16
  localparam int PI_Q16               = 205887;
  localparam int HALF_PI_Q16          = 102944;
  localparam int QUARTER_PI_Q16       = 51472;
  localparam int THREE_QUARTER_PI_Q16 = 154416;
  localparam int TWO_PI_Q16           = 411774;
  localparam int ONE_Q14              = 16384;
  localparam int CORDIC_X0            = 652032874;
  localparam int CORDIC_STEPS         = 16;

  localparam int N_LANES = 7;
  localparam int N_POSES = 6;

  // Rotation axis of each transform in the chain: 1 about y, 0 about x
  localparam logic [N_LANES-1:0] LANE_AXIS_Y = 7'b0111010;

  localparam logic [2:0] LAST_JOINT = 3'd5;

  localparam logic signed [ZW-1:0] Z_PI      = ZW'(PI_Q16);
  localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(HALF_PI_Q16);
  localparam logic signed [ZW-1:0] Z_TWO_PI  = ZW'(TWO_PI_Q16);

  localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIP_OFFSET_DOWN = 4'd0,
    CFG_HIP_OFFSET_SIDE = 4'd1,
    CFG_THIGH_LEN       = 4'd2,
    CFG_TIBIA_LEN       = 4'd3
  } cfg_idx_t;

  typedef logic signed [Q14_W-1:0]  q14_t;
  typedef q14_t [2:0][2:0]          mat_t;
  typedef logic signed [PINT_W-1:0] pint_t;
  typedef pint_t [2:0]              pvec_t;

  typedef struct packed {
    mat_t  r;
    pvec_t p;
  } pose_t;

  // Number of conditional-subtract steps for the 2*pi reduction
  function automatic int red_steps(input int aqw);
    return (aqw > 19) ? aqw - 18 : 1;
  endfunction

  // Round to nearest (half up) after a floor shift, clamp to +-1.0 in Q2.14
  function automatic q14_t rnd_clamp(input logic signed [35:0] v, input int sh);
    logic signed [35:0] t;
    t = (v + (36'sd1 <<< (sh - 1))) >>> sh;
    if (t > 36'sd16384) begin
      return q14_t'(ONE_Q14);
    end else if (t < -36'sd16384) begin
      return -q14_t'(ONE_Q14);
    end
    return Q14_W'(t);
  endfunction

endpackage

[rtl/core/lfk_in_if.sv]
`timescale 1ns / 1ps

interface lfk_in_if #(parameter int ANGLE_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [ANGLE_WIDTH-1:0] hip_yaw_pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] hip_roll_angle;
  logic signed [ANGLE_WIDTH-1:0] hip_pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] knee_pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] ankle_pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] ankle_roll_angle;

  modport source (
    output valid, cmd, hip_yaw_pitch_angle, hip_roll_angle, hip_pitch_angle,
           knee_pitch_angle, ankle_pitch_angle, ankle_roll_angle,
    input  ready
  );
  modport sink (
    input  valid, cmd, hip_yaw_pitch_angle, hip_roll_angle, hip_pitch_angle,
           knee_pitch_angle, ankle_pitch_angle, ankle_roll_angle,
    output ready
  );
endinterface

[rtl/core/lfk_out_if.sv]
`timescale 1ns / 1ps

interface lfk_out_if #(parameter int POS_WIDTH = 20) ();
  logic                        valid;
  logic                        ready;
  logic [2:0]                  joint_index;
  logic signed [15:0]          rot_xx;
  logic signed [15:0]          rot_yx;
  logic signed [15:0]          rot_zx;
  logic signed [15:0]          rot_xy;
  logic signed [15:0]          rot_yy;
  logic signed [15:0]          rot_zy;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;
  logic                        last_pose;

  modport source (
    output valid, joint_index, rot_xx, rot_yx, rot_zx, rot_xy, rot_yy, rot_zy,
           pos_x, pos_y, pos_z, last_pose,
    input  ready
  );
  modport sink (
    input  valid, joint_index, rot_xx, rot_yx, rot_zx, rot_xy, rot_yy, rot_zy,
           pos_x, pos_y, pos_z, last_pose,
    output ready
  );
endinterface

[rtl/core/lfk_cfg_if.sv]
`timescale 1ns / 1ps

interface lfk_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [lfk_pkg::CFG_IDX_W-1:0]   index;
  logic [lfk_pkg::CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/lfk_sincos.sv]
`timescale 1ns / 1ps

module lfk_sincos #(
  parameter int AQW = 20
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AQW-1:0] ang,
  output lfk_pkg::q14_t         cos_q,
  output lfk_pkg::q14_t         sin_q
);
  import lfk_pkg::*;

  localparam int NRED = red_steps(AQW);
  localparam int K    = NRED - 1;
  localparam int RW   = RED_BASE + K;
  localparam logic [RW-1:0] TWO_PI_W = RW'(TWO_PI_Q16);
  localparam logic [RW-1:0] OFFS     = TWO_PI_W << K;

  // 2*pi reduction, one conditional subtract a stage
  logic [RW-1:0] red_src [NRED];
  logic [RW-1:0] red_nxt [NRED];
  logic [RW-1:0] red_r   [NRED];

  for (genvar s = 0; s < NRED; s++) begin : g_red
    localparam logic [RW-1:0] STEP = TWO_PI_W << (K - s);
    if (s == 0) begin : g_first
      assign red_src[s] = RW'(ang) + OFFS;
    end else begin : g_next
      assign red_src[s] = red_r[s-1];
    end
    assign red_nxt[s] = (red_src[s] >= STEP) ? red_src[s] - STEP : red_src[s];
    always_ff @(posedge clk) begin
      if (en) begin
        red_r[s] <= red_nxt[s];
      end
    end
  end

  // Fold into (-pi, pi], then into [-pi/2, pi/2] with a sign flag
  logic signed [ZW-1:0] zw;
  logic signed [ZW-1:0] fold_nxt;
  logic                 neg_nxt;
  logic signed [ZW-1:0] fold_r;
  logic                 neg_fold_r;

  always_comb begin
    zw = $signed(red_r[NRED-1][ZW-1:0]);
    if (zw > Z_PI) begin
      zw = zw - Z_TWO_PI;
    end
    fold_nxt = zw;
    neg_nxt  = 1'b0;
    if (zw > Z_HALF_PI) begin
      fold_nxt = zw - Z_PI;
      neg_nxt  = 1'b1;
    end else if (zw < -Z_HALF_PI) begin
      fold_nxt = zw + Z_PI;
      neg_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold_r     <= fold_nxt;
      neg_fold_r <= neg_nxt;
    end
  end

  // CORDIC rotation, one iteration a stage
  logic signed [XYW-1:0] x_in [CORDIC_STEPS];
  logic signed [XYW-1:0] y_in [CORDIC_STEPS];
  logic signed [ZW-1:0]  z_in [CORDIC_STEPS];
  logic                  n_in [CORDIC_STEPS];
  logic signed [XYW-1:0] x_r  [CORDIC_STEPS];
  logic signed [XYW-1:0] y_r  [CORDIC_STEPS];
  logic signed [ZW-1:0]  z_r  [CORDIC_STEPS];
  logic                  n_r  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    if (i == 0) begin : g_first
      assign x_in[i] = XYW'(CORDIC_X0);
      assign y_in[i] = '0;
      assign z_in[i] = fold_r;
      assign n_in[i] = neg_fold_r;
    end else begin : g_next
      assign x_in[i] = x_r[i-1];
      assign y_in[i] = y_r[i-1];
      assign z_in[i] = z_r[i-1];
      assign n_in[i] = n_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= n_in[i];
        if (!z_in[i][ZW-1]) begin
          x_r[i] <= x_in[i] - (y_in[i] >>> i);
          y_r[i] <= y_in[i] + (x_in[i] >>> i);
          z_r[i] <= z_in[i] - ATAN_Q16[i];
        end else begin
          x_r[i] <= x_in[i] + (y_in[i] >>> i);
          y_r[i] <= y_in[i] - (x_in[i] >>> i);
          z_r[i] <= z_in[i] + ATAN_Q16[i];
        end
      end
    end
  end

  // Round to Q2.14, clamp, apply the fold sign
  q14_t c_nxt;
  q14_t s_nxt;
  q14_t c_r;
  q14_t s_r;

  always_comb begin
    c_nxt = rnd_clamp(36'(x_r[CORDIC_STEPS-1]), 16);
    s_nxt = rnd_clamp(36'(y_r[CORDIC_STEPS-1]), 16);
    if (n_r[CORDIC_STEPS-1]) begin
      c_nxt = -c_nxt;
      s_nxt = -s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
    end
  end

  assign cos_q = c_r;
  assign sin_q = s_r;

endmodule

[rtl/core/lfk_rotate.sv]
`timescale 1ns / 1ps

module lfk_rotate (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      axis_y,
  input  lfk_pkg::mat_t             r_in,
  input  lfk_pkg::pvec_t            p_in,
  input  lfk_pkg::q14_t             cos_q,
  input  lfk_pkg::q14_t             sin_q,
  input  logic [lfk_pkg::CFG_W-1:0] len,
  output lfk_pkg::mat_t             r_out,
  output lfk_pkg::pvec_t            p_out
);
  import lfk_pkg::*;

  // Stage 1: products of the two moving columns and the drop along local z
  q14_t                u_s    [3];
  q14_t                w_s    [3];
  q14_t                keep_nxt [3];
  logic signed [31:0]  pa_nxt [3];
  logic signed [31:0]  pb_nxt [3];
  logic signed [31:0]  pd_nxt [3];
  logic signed [31:0]  pe_nxt [3];
  logic signed [34:0]  q_nxt  [3];

  q14_t                keep_r [3];
  logic signed [31:0]  pa_r   [3];
  logic signed [31:0]  pb_r   [3];
  logic signed [31:0]  pd_r   [3];
  logic signed [31:0]  pe_r   [3];
  logic signed [34:0]  q_r    [3];
  pvec_t               p_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_s[i]      = axis_y ? $signed(r_in[i][0]) : $signed(r_in[i][1]);
      keep_nxt[i] = axis_y ? $signed(r_in[i][1]) : $signed(r_in[i][0]);
      w_s[i]      = $signed(r_in[i][2]);
      pa_nxt[i]   = u_s[i] * cos_q;
      pb_nxt[i]   = w_s[i] * sin_q;
      pd_nxt[i]   = u_s[i] * sin_q;
      pe_nxt[i]   = w_s[i] * cos_q;
      q_nxt[i]    = w_s[i] * $signed({1'b0, len});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      keep_r <= keep_nxt;
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      pd_r   <= pd_nxt;
      pe_r   <= pe_nxt;
      q_r    <= q_nxt;
      p_r    <= p_in;
    end
  end

  // Stage 2: sums, rounding, clamping, position update
  logic signed [33:0] s1 [3];
  logic signed [33:0] s2 [3];
  q14_t               rc1 [3];
  q14_t               rc2 [3];
  mat_t               r_nxt;
  pvec_t              p_nxt;
  mat_t               r_r;
  pvec_t              po_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1[i]  = axis_y ? 34'(pa_r[i]) - 34'(pb_r[i]) : 34'(pa_r[i]) + 34'(pb_r[i]);
      s2[i]  = axis_y ? 34'(pd_r[i]) + 34'(pe_r[i]) : 34'(pe_r[i]) - 34'(pd_r[i]);
      rc1[i] = rnd_clamp(36'(s1[i]), 14);
      rc2[i] = rnd_clamp(36'(s2[i]), 14);
      if (axis_y) begin
        r_nxt[i][0] = rc1[i];
        r_nxt[i][1] = keep_r[i];
      end else begin
        r_nxt[i][0] = keep_r[i];
        r_nxt[i][1] = rc1[i];
      end
      r_nxt[i][2] = rc2[i];
      p_nxt[i] = $signed(p_r[i]) - PINT_W'((36'(q_r[i]) + 36'sd8192) >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r  <= r_nxt;
      po_r <= p_nxt;
    end
  end

  assign r_out = r_r;
  assign p_out = po_r;

endmodule

[rtl/core/leg_forward_kinematics.sv]
`timescale 1ns / 1ps
// Leg forward kinematics, torso frame, fixed point.
// Channels: in_ch takes one item per leg command (side bit and six joint
// angles, Q3.13 rad); out_ch gives six poses per item, joint_index 0 to 5,
// last_pose on the sixth; cfg_ch writes the four length registers and is
// always ready.
// Path from acceptance to the first pose: S reduction stages, where S is the
// number of 2*pi reduction steps (2 at ANGLE_WIDTH 16), a fold stage, 16
// CORDIC stages, a rounding stage, seven two-stage rotation units, then the
// pose buffer. The item rate is set by the single result port, which sends
// six poses per item; the pipeline accepts an item every cycle until its last
// stage holds an item and the pose buffer is busy.
// Reset: clears all valid bits and the pose counter, and loads the default
// lengths. When the receiver stalls, the whole pipeline holds in place once
// its last stage holds an item; nothing is dropped or repeated.
module leg_forward_kinematics #(
  parameter int ANGLE_WIDTH = 16,
  parameter int POS_WIDTH   = 20
) (
  input logic       clk,
  input logic       rst_n,
  lfk_in_if.sink    in_ch,
  lfk_out_if.source out_ch,
  lfk_cfg_if.sink   cfg_ch
);
  import lfk_pkg::*;

  localparam int AQW  = ((ANGLE_WIDTH + 2 > 18) ? ANGLE_WIDTH + 2 : 18) + 2;
  localparam int D_SC = red_steps(AQW) + 18;
  localparam int NV   = D_SC + 2 * N_LANES;
  localparam int EW   = ((PINT_W > POS_WIDTH) ? PINT_W : POS_WIDTH) + 1;
  localparam logic signed [EW-1:0] POS_HI = EW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] POS_LO = -POS_HI - EW'(1);
  localparam logic signed [AQW-1:0] A_Q  = AQW'(QUARTER_PI_Q16);
  localparam logic signed [AQW-1:0] A_3Q = AQW'(THREE_QUARTER_PI_Q16);

  // Length registers
  logic [CFG_W-1:0] hip_down_r;
  logic [CFG_W-1:0] hip_side_r;
  logic [CFG_W-1:0] thigh_r;
  logic [CFG_W-1:0] tibia_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hip_down_r <= CFG_W'(85000);
      hip_side_r <= CFG_W'(50000);
      thigh_r    <= CFG_W'(100000);
      tibia_r    <= CFG_W'(102900);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_HIP_OFFSET_DOWN: hip_down_r <= cfg_ch.data;
        CFG_HIP_OFFSET_SIDE: hip_side_r <= cfg_ch.data;
        CFG_THIGH_LEN:       thigh_r    <= cfg_ch.data;
        CFG_TIBIA_LEN:       tibia_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Pipeline advance
  logic            en;
  logic            ser_free;
  logic            ser_load;
  logic [NV-1:0]   vld_r;
  logic [D_SC-1:0] side_r;

  assign en          = !vld_r[NV-1] || ser_free;
  assign ser_load    = vld_r[NV-1] && ser_free;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= {side_r[D_SC-2:0], in_ch.cmd};
    end
  end

  // Joint angles to Q.16 and the seven rotation angles
  logic signed [AQW-1:0] ang [6];
  logic signed [AQW-1:0] lane_ang [N_LANES];

  always_comb begin
    ang[0] = AQW'($signed({in_ch.hip_yaw_pitch_angle, 3'b000}));
    ang[1] = AQW'($signed({in_ch.hip_roll_angle, 3'b000}));
    ang[2] = AQW'($signed({in_ch.hip_pitch_angle, 3'b000}));
    ang[3] = AQW'($signed({in_ch.knee_pitch_angle, 3'b000}));
    ang[4] = AQW'($signed({in_ch.ankle_pitch_angle, 3'b000}));
    ang[5] = AQW'($signed({in_ch.ankle_roll_angle, 3'b000}));
    lane_ang[0] = in_ch.cmd ? -A_3Q : -A_Q;
    lane_ang[1] = in_ch.cmd ? -ang[0] : ang[0];
    lane_ang[2] = (in_ch.cmd ? A_3Q : A_Q) + ang[1];
    for (int j = 3; j < N_LANES; j++) begin
      lane_ang[j] = ang[j-1];
    end
  end

  // Sine and cosine lanes, each after the first delayed to meet its rotation unit
  q14_t sc_c  [N_LANES];
  q14_t sc_s  [N_LANES];
  q14_t rot_c [N_LANES];
  q14_t rot_s [N_LANES];

  for (genvar j = 0; j < N_LANES; j++) begin : g_lane
    lfk_sincos #(.AQW(AQW)) u_sincos (
      .clk   (clk),
      .en    (en),
      .ang   (lane_ang[j]),
      .cos_q (sc_c[j]),
      .sin_q (sc_s[j])
    );
    if (j == 0) begin : g_direct
      assign rot_c[j] = sc_c[j];
      assign rot_s[j] = sc_s[j];
    end else begin : g_delay
      q14_t dc_r [2*j];
      q14_t ds_r [2*j];
      always_ff @(posedge clk) begin
        if (en) begin
          dc_r[0] <= sc_c[j];
          ds_r[0] <= sc_s[j];
          for (int k = 1; k < 2 * j; k++) begin
            dc_r[k] <= dc_r[k-1];
            ds_r[k] <= ds_r[k-1];
          end
        end
      end
      assign rot_c[j] = dc_r[2*j-1];
      assign rot_s[j] = ds_r[2*j-1];
    end
  end

  // Transform chain: tilt, yaw-pitch, roll, pitch, knee, ankle pitch, ankle roll
  mat_t             id_m;
  pvec_t            p_init;
  mat_t             r_in  [N_LANES];
  pvec_t            p_in  [N_LANES];
  mat_t             r_out [N_LANES];
  pvec_t            p_out [N_LANES];
  logic [CFG_W-1:0] len   [N_LANES];

  always_comb begin
    id_m = '0;
    for (int i = 0; i < 3; i++) begin
      id_m[i][i] = q14_t'(ONE_Q14);
    end
    p_init[0] = '0;
    p_init[1] = side_r[D_SC-1] ? -PINT_W'($signed({1'b0, hip_side_r}))
                               :  PINT_W'($signed({1'b0, hip_side_r}));
    p_init[2] = -PINT_W'($signed({1'b0, hip_down_r}));
    for (int j = 0; j < N_LANES; j++) begin
      len[j] = '0;
    end
    len[4] = thigh_r;
    len[5] = tibia_r;
  end

  for (genvar j = 0; j < N_LANES; j++) begin : g_rot
    if (j == 0) begin : g_first
      assign r_in[j] = id_m;
      assign p_in[j] = p_init;
    end else begin : g_next
      assign r_in[j] = r_out[j-1];
      assign p_in[j] = p_out[j-1];
    end
    lfk_rotate u_rotate (
      .clk    (clk),
      .en     (en),
      .axis_y (LANE_AXIS_Y[j]),
      .r_in   (r_in[j]),
      .p_in   (p_in[j]),
      .cos_q  (rot_c[j]),
      .sin_q  (rot_s[j]),
      .len    (len[j]),
      .r_out  (r_out[j]),
      .p_out  (p_out[j])
    );
  end

  // Align the six poses with the last stage
  pose_t pose_end [N_POSES];

  for (genvar k = 0; k < N_POSES; k++) begin : g_pose
    pose_t pose_src;
    assign pose_src.r = r_out[k+1];
    assign pose_src.p = p_out[k+1];
    if (k == N_POSES - 1) begin : g_direct
      assign pose_end[k] = pose_src;
    end else begin : g_delay
      pose_t dp_r [2*(N_POSES-1-k)];
      always_ff @(posedge clk) begin
        if (en) begin
          dp_r[0] <= pose_src;
          for (int m = 1; m < 2 * (N_POSES - 1 - k); m++) begin
            dp_r[m] <= dp_r[m-1];
          end
        end
      end
      assign pose_end[k] = dp_r[2*(N_POSES-1-k)-1];
    end
  end

  // Pose buffer, one pose a cycle to the result port while the receiver is ready
  pose_t      buf_r [N_POSES];
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;

  assign ser_free = !out_valid_r || (out_ch.ready && cnt_r == LAST_JOINT);

  always_comb begin
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    if (ser_load) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = '0;
    end else if (out_valid_r && out_ch.ready) begin
      if (cnt_r == LAST_JOINT) begin
        out_valid_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      buf_r <= pose_end;
    end
  end

  // Output fields, positions saturated
  function automatic logic signed [POS_WIDTH-1:0] sat_pos(input pint_t v);
    logic signed [EW-1:0] w;
    w = EW'(v);
    if (w > POS_HI) begin
      w = POS_HI;
    end else if (w < POS_LO) begin
      w = POS_LO;
    end
    return POS_WIDTH'(w);
  endfunction

  pose_t cur;
  assign cur = buf_r[cnt_r];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.joint_index = cnt_r;
  assign out_ch.rot_xx      = cur.r[0][0];
  assign out_ch.rot_yx      = cur.r[1][0];
  assign out_ch.rot_zx      = cur.r[2][0];
  assign out_ch.rot_xy      = cur.r[0][1];
  assign out_ch.rot_yy      = cur.r[1][1];
  assign out_ch.rot_zy      = cur.r[2][1];
  assign out_ch.pos_x       = sat_pos(cur.p[0]);
  assign out_ch.pos_y       = sat_pos(cur.p[1]);
  assign out_ch.pos_z       = sat_pos(cur.p[2]);
  assign out_ch.last_pose   = (cnt_r == LAST_JOINT);

endmodule
